// File: rtl/core/eip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eip_pkg;

  localparam logic [1:0] OP_ENTER = 2'd0;
  localparam logic [1:0] OP_LEAVE = 2'd1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  localparam int unsigned CFG_AW = 3;
  localparam logic REG_FRAME_CODE = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  worker_id;
    logic [7:0]  event_type;
    logic [63:0] timestamp;
    logic        bad;
    logic        frame;
  } eip_item_t;

endpackage
`default_nettype wire

// File: rtl/core/event_interval_profiler.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake                  | payload
// in_       | in_push / in_full          | opcode, worker_id, event_type, timestamp
// out_      | out_pop / out_empty        | status, event_cycles, longest_cycles,
//           |                            | largest_valid, largest_index, frame_count
// apb       | psel penable pwrite pready | paddr, pwdata, prdata (frame_code at 0)
// A bad-worker request goes straight to the result; enter, signal and frame enter/signal
// read the statistics and write once; a frame leave also reads entry 0; any other leave
// walks back one entry at a time from the newest, then re-reads the largest entry if live.
// Per-item time is set by the one read address shared by the entry memories.
// After reset a clearing pass over all WORKERS * 2**clog2(EVENTS) entries (8192 by
// default) holds in_full high. A two-deep input queue and the result register let
// each side stall without blocking the other.
module event_interval_profiler #(
  parameter int WORKERS = 8,
  parameter int EVENTS  = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [7:0]                  in_worker_id,
  input  wire logic [7:0]                  in_event_type,
  input  wire logic [63:0]                 in_timestamp,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [1:0]                       out_status,
  output logic [63:0]                      out_event_cycles,
  output logic [63:0]                      out_longest_cycles,
  output logic                             out_largest_valid,
  output logic [9:0]                       out_largest_index,
  output logic [31:0]                      out_frame_count,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [eip_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [7:0]         frame_code_r;
  logic               hold;
  logic               head_valid, head_pop;
  eip_pkg::eip_item_t head;
  logic               out_valid;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == eip_pkg::REG_FRAME_CODE) ? {24'd0, frame_code_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_code_r <= 8'd0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == eip_pkg::REG_FRAME_CODE) begin
      frame_code_r <= pwdata[7:0];
    end
  end

  eip_front #(.WORKERS(WORKERS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .opcode     (in_opcode),
    .worker_id  (in_worker_id),
    .event_type (in_event_type),
    .timestamp  (in_timestamp),
    .frame_code (frame_code_r),
    .hold       (hold),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  eip_back #(.WORKERS(WORKERS), .EVENTS(EVENTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy_clear  (hold),
    .head_valid  (head_valid),
    .head        (head),
    .head_pop    (head_pop),
    .out_valid   (out_valid),
    .out_pop     (out_pop),
    .out_status  (out_status),
    .out_cycles  (out_event_cycles),
    .out_longest (out_longest_cycles),
    .out_lvalid  (out_largest_valid),
    .out_lindex  (out_largest_index),
    .out_frames  (out_frame_count)
  );

  assign out_empty = !out_valid;

endmodule
`default_nettype wire

// File: rtl/core/eip_front.sv
`timescale 1ns / 1ps
`default_nettype none
module eip_front #(
  parameter int WORKERS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [1:0]          opcode,
  input  wire logic [7:0]          worker_id,
  input  wire logic [7:0]          event_type,
  input  wire logic [63:0]         timestamp,
  input  wire logic [7:0]          frame_code,
  input  wire logic                hold,
  output logic                     head_valid,
  output eip_pkg::eip_item_t       head,
  input  wire logic                head_pop
);

  eip_pkg::eip_item_t slot_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic               push_ok, pop_ok;
  eip_pkg::eip_item_t item;

  always_comb begin
    item.opcode     = opcode;
    item.worker_id  = worker_id;
    item.event_type = event_type;
    item.timestamp  = timestamp;
    item.bad        = ({1'b0, worker_id} >= 9'(WORKERS));
    item.frame      = (event_type == frame_code);
  end

  assign full       = (cnt_r == 2'd2) || hold;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = slot_r[rp_r];
  assign push_ok    = push && !full;
  assign pop_ok     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (pop_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) slot_r[wp_r] <= item;
  end

endmodule
`default_nettype wire

// File: rtl/core/eip_back.sv
`timescale 1ns / 1ps
`default_nettype none
module eip_back #(
  parameter int WORKERS = 8,
  parameter int EVENTS  = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  output logic                     busy_clear,
  input  wire logic                head_valid,
  input  wire eip_pkg::eip_item_t  head,
  output logic                     head_pop,
  output logic                     out_valid,
  input  wire logic                out_pop,
  output logic [1:0]               out_status,
  output logic [63:0]              out_cycles,
  output logic [63:0]              out_longest,
  output logic                     out_lvalid,
  output logic [9:0]               out_lindex,
  output logic [31:0]              out_frames
);

  localparam int IW    = $clog2(EVENTS);
  localparam int CW    = IW + 1;
  localparam int WW    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int AW    = WW + IW;
  localparam int DEPTH = WORKERS * (2 ** IW);
  localparam int CLW   = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [CW-1:0] count;
    logic [IW-1:0] slot;
    logic          live;
    logic [63:0]   longest;
    logic [31:0]   frames;
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_STAT, S_FRAME, S_SRCH, S_LARG, S_CMP, S_FIN
  } state_t;

  logic [7:0]  type_mem  [DEPTH];
  logic [63:0] enter_mem [DEPTH];
  logic [63:0] leave_mem [DEPTH];
  stat_t       stat_mem  [WORKERS];

  logic [7:0]  rd_type_r;
  logic [63:0] rd_enter_r, rd_leave_r;
  stat_t       st_rd_r;

  state_t             state_r, state_nxt;
  logic [CLW-1:0]     clr_r, clr_nxt;
  eip_pkg::eip_item_t item_r, item_nxt;
  stat_t              st_r, st_nxt;
  logic [IW-1:0]      k_r, k_nxt, idx_r, idx_nxt;
  logic [63:0]        cyc_r, cyc_nxt, prev_r, prev_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               upd_long_r, upd_long_nxt, wr_stat_r, wr_stat_nxt;
  logic               ls_hit_r, ls_hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [63:0]        out_cycles_r, out_cycles_nxt, out_longest_r, out_longest_nxt;
  logic               out_lvalid_r, out_lvalid_nxt;
  logic [9:0]         out_lindex_r, out_lindex_nxt;
  logic [31:0]        out_frames_r, out_frames_nxt;

  logic [AW-1:0] raddr, waddr;
  logic          we_type, we_enter, we_leave;
  logic [7:0]    w_type;
  logic [63:0]   w_enter, w_leave;
  logic [WW-1:0] st_raddr, st_waddr;
  logic          st_we;
  stat_t         st_wdata;

  function automatic logic [AW-1:0] ent_addr(input logic [7:0] w, input logic [IW-1:0] i);
    return {w[WW-1:0], i};
  endfunction

  assign busy_clear  = (clr_r < CLW'(DEPTH));
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_cycles  = out_cycles_r;
  assign out_longest = out_longest_r;
  assign out_lvalid  = out_lvalid_r;
  assign out_lindex  = out_lindex_r;
  assign out_frames  = out_frames_r;

  always_comb begin
    logic [CW-1:0] n;
    logic [63:0]   lng;
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    item_nxt       = item_r;
    st_nxt         = st_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    cyc_nxt        = cyc_r;
    prev_nxt       = prev_r;
    status_nxt     = status_r;
    upd_long_nxt   = upd_long_r;
    wr_stat_nxt    = wr_stat_r;
    ls_hit_nxt     = ls_hit_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    out_status_nxt = out_status_r;
    out_cycles_nxt = out_cycles_r;
    out_longest_nxt = out_longest_r;
    out_lvalid_nxt = out_lvalid_r;
    out_lindex_nxt = out_lindex_r;
    out_frames_nxt = out_frames_r;
    head_pop  = 1'b0;
    raddr     = ent_addr(item_r.worker_id, k_r);
    waddr     = ent_addr(item_r.worker_id, k_r);
    we_type   = 1'b0;
    we_enter  = 1'b0;
    we_leave  = 1'b0;
    w_type    = item_r.event_type;
    w_enter   = item_r.timestamp;
    w_leave   = item_r.timestamp;
    st_raddr  = item_r.worker_id[WW-1:0];
    st_waddr  = item_r.worker_id[WW-1:0];
    st_we     = 1'b0;
    st_wdata  = st_r;
    n         = st_rd_r.count;
    lng       = st_r.longest;

    unique case (state_r)
      S_IDLE: begin
        if (busy_clear) begin
          clr_nxt  = clr_r + 1'b1;
          waddr    = clr_r[AW-1:0];
          we_type  = 1'b1;
          we_enter = 1'b1;
          we_leave = 1'b1;
          w_type   = '0;
          w_enter  = '0;
          w_leave  = '0;
          if (clr_r < CLW'(WORKERS)) begin
            st_we    = 1'b1;
            st_waddr = clr_r[WW-1:0];
            st_wdata = '0;
          end
        end else if (head_valid) begin
          head_pop = 1'b1;
          item_nxt = head;
          st_raddr = head.worker_id[WW-1:0];
          cyc_nxt  = '0;
          upd_long_nxt = 1'b0;
          if (head.bad) begin
            status_nxt  = eip_pkg::ST_BAD;
            st_nxt      = '0;
            wr_stat_nxt = 1'b0;
            state_nxt   = S_FIN;
          end else begin
            status_nxt  = eip_pkg::ST_DONE;
            wr_stat_nxt = 1'b1;
            state_nxt   = S_STAT;
          end
        end
      end
      S_STAT: begin
        st_nxt = st_rd_r;
        if (item_r.frame) begin
          if (item_r.opcode == eip_pkg::OP_ENTER) begin
            waddr    = ent_addr(item_r.worker_id, '0);
            we_type  = 1'b1;
            we_enter = 1'b1;
            we_leave = 1'b1;
            w_leave  = '0;
            st_nxt.live  = 1'b0;
            st_nxt.slot  = '0;
            st_nxt.count = CW'(1);
            state_nxt = S_FIN;
          end else if (item_r.opcode == eip_pkg::OP_LEAVE) begin
            raddr     = ent_addr(item_r.worker_id, '0);
            state_nxt = S_FRAME;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (item_r.opcode == eip_pkg::OP_LEAVE) begin
          if (n == '0) begin
            status_nxt = eip_pkg::ST_NOMATCH;
            state_nxt  = S_FIN;
          end else begin
            k_nxt     = IW'(n - 1'b1);
            raddr     = ent_addr(item_r.worker_id, IW'(n - 1'b1));
            state_nxt = S_SRCH;
          end
        end else begin
          if (n >= CW'(EVENTS)) begin
            status_nxt = eip_pkg::ST_FULL;
          end else begin
            waddr   = ent_addr(item_r.worker_id, n[IW-1:0]);
            we_type = 1'b1;
            we_leave = 1'b1;
            if (item_r.opcode == eip_pkg::OP_ENTER) begin
              we_enter = 1'b1;
              w_leave  = '0;
            end
            st_nxt.count = n + 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_FRAME: begin
        waddr    = ent_addr(item_r.worker_id, '0);
        we_leave = 1'b1;
        cyc_nxt  = item_r.timestamp - rd_enter_r;
        st_nxt.frames = st_r.frames + 1'b1;
        state_nxt = S_FIN;
      end
      S_SRCH: begin
        if (rd_type_r == item_r.event_type && rd_leave_r == '0) begin
          we_leave     = 1'b1;
          cyc_nxt      = item_r.timestamp - rd_enter_r;
          idx_nxt      = k_r;
          upd_long_nxt = 1'b1;
          if (!st_r.live) begin
            st_nxt.live = 1'b1;
            st_nxt.slot = k_r;
            state_nxt   = S_FIN;
          end else begin
            raddr      = ent_addr(item_r.worker_id, st_r.slot);
            ls_hit_nxt = (st_r.slot == k_r);
            state_nxt  = S_LARG;
          end
        end else if (k_r == '0) begin
          status_nxt = eip_pkg::ST_NOMATCH;
          state_nxt  = S_FIN;
        end else begin
          k_nxt = k_r - 1'b1;
          raddr = ent_addr(item_r.worker_id, k_r - 1'b1);
        end
      end
      S_LARG: begin
        prev_nxt  = rd_leave_r - rd_enter_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!ls_hit_r && cyc_r > prev_r) st_nxt.slot = idx_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_pop) begin
          if (upd_long_r && st_r.longest < cyc_r) lng = cyc_r;
          st_wdata         = st_r;
          st_wdata.longest = lng;
          st_we            = wr_stat_r;
          out_valid_nxt    = 1'b1;
          out_status_nxt   = status_r;
          out_cycles_nxt   = cyc_r;
          out_longest_nxt  = lng;
          out_lvalid_nxt   = st_r.live;
          out_lindex_nxt   = st_r.live ? 10'(st_r.slot) : 10'd0;
          out_frames_nxt   = st_r.frames;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      out_valid_r   <= out_valid_nxt;
      item_r        <= item_nxt;
      st_r          <= st_nxt;
      k_r           <= k_nxt;
      idx_r         <= idx_nxt;
      cyc_r         <= cyc_nxt;
      prev_r        <= prev_nxt;
      status_r      <= status_nxt;
      upd_long_r    <= upd_long_nxt;
      wr_stat_r     <= wr_stat_nxt;
      ls_hit_r      <= ls_hit_nxt;
      out_status_r  <= out_status_nxt;
      out_cycles_r  <= out_cycles_nxt;
      out_longest_r <= out_longest_nxt;
      out_lvalid_r  <= out_lvalid_nxt;
      out_lindex_r  <= out_lindex_nxt;
      out_frames_r  <= out_frames_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we_type) type_mem[waddr] <= w_type;
    rd_type_r <= type_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_enter) enter_mem[waddr] <= w_enter;
    rd_enter_r <= enter_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_leave) leave_mem[waddr] <= w_leave;
    rd_leave_r <= leave_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) stat_mem[st_waddr] <= st_wdata;
    st_rd_r <= stat_mem[st_raddr];
  end

`ifndef ASSERT_OFF
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy_clear |-> !head_pop)
    else $error("request taken during clearing pass");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == eip_pkg::ST_BAD) |->
    (out_cycles_r == '0 && out_longest_r == '0 && out_frames_r == '0 && !out_lvalid_r))
    else $error("bad worker result carries statistics");
  a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_pop) |=> (state_r == S_FIN && out_valid_r))
    else $error("result overwritten while pending");
`endif

endmodule
`default_nettype wire
